FILE: design/pfs_pkg.sv
// Shared types and operation codes of the primitive field serializer.
package pfs_pkg;

  localparam int ValueWidth = 64;
  localparam int OffsetWidth = 48;

  localparam logic [2:0] OP_BYTE     = 3'd0;
  localparam logic [2:0] OP_INT16    = 3'd1;
  localparam logic [2:0] OP_INT32    = 3'd2;
  localparam logic [2:0] OP_INT64    = 3'd3;
  localparam logic [2:0] OP_VARINT32 = 3'd4;
  localparam logic [2:0] OP_VARINT64 = 3'd5;

  typedef struct packed {
    logic [2:0]            operation;
    logic [ValueWidth-1:0] value;
  } pfs_in_t;

  typedef struct packed {
    logic [7:0]             out_byte;
    logic [OffsetWidth-1:0] byte_offset;
    logic                   last;
  } pfs_out_t;

  // Current digit offered by the shifter.
  typedef struct packed {
    logic       busy;
    logic [7:0] data;
    logic       last;
  } pfs_digit_t;

endpackage

FILE: design/pfs_shifter.sv
// Byte-serial shift register: big-endian and 7-bit group forms.
module pfs_shifter (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  pfs_pkg::pfs_in_t item,
  input  logic            step,
  output pfs_pkg::pfs_digit_t digit
);
  import pfs_pkg::*;

  logic [ValueWidth-1:0] sr_r, sr_nxt;
  logic [2:0]            cnt_r, cnt_nxt;
  logic                  varint_r, varint_nxt;
  logic                  busy_r, busy_nxt;
  logic                  more;

  // more groups follow the current one
  assign more = |sr_r[ValueWidth-1:7];

  always_comb begin
    digit.busy = busy_r;
    if (varint_r) begin
      digit.data = {more, sr_r[6:0]};
      digit.last = !more;
    end else begin
      digit.data = sr_r[ValueWidth-1:ValueWidth-8];
      digit.last = (cnt_r == 3'd0);
    end
  end

  always_comb begin
    sr_nxt     = sr_r;
    cnt_nxt    = cnt_r;
    varint_nxt = varint_r;
    busy_nxt   = busy_r;
    if (step && busy_r) begin
      if (digit.last) begin
        busy_nxt = 1'b0;
      end
      if (varint_r) begin
        sr_nxt = sr_r >> 7;
      end else begin
        sr_nxt = sr_r << 8;
      end
      cnt_nxt = cnt_r - 3'd1;
    end
    if (load) begin
      busy_nxt   = 1'b1;
      varint_nxt = 1'b0;
      cnt_nxt    = 3'd0;
      sr_nxt     = item.value;
      case (item.operation)
        OP_BYTE: begin
          sr_nxt = {item.value[7:0], 56'd0};
        end
        OP_INT16: begin
          sr_nxt  = {item.value[15:0], 48'd0};
          cnt_nxt = 3'd1;
        end
        OP_INT32: begin
          sr_nxt  = {item.value[31:0], 32'd0};
          cnt_nxt = 3'd3;
        end
        OP_INT64: begin
          cnt_nxt = 3'd7;
        end
        OP_VARINT32: begin
          sr_nxt     = {32'd0, item.value[31:0]};
          varint_nxt = 1'b1;
        end
        OP_VARINT64: begin
          varint_nxt = 1'b1;
        end
        default: begin
          // undefined code: item dropped
          busy_nxt = 1'b0;
          sr_nxt   = sr_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    sr_r     <= sr_nxt;
    cnt_r    <= cnt_nxt;
    varint_r <= varint_nxt;
  end

endmodule

FILE: design/pfs_position.sv
// Running stream position counter, wrapping at its width.
module pfs_position #(
  parameter int PositionWidth = 48
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           inc,
  output logic [pfs_pkg::OffsetWidth-1:0] offset
);
  import pfs_pkg::*;

  logic [PositionWidth-1:0] pos_r, pos_nxt;
  logic [63:0]              pos_ext;

  assign pos_nxt = inc ? pos_r + 1'b1 : pos_r;
  assign pos_ext = 64'(pos_r);
  assign offset  = pos_ext[OffsetWidth-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

FILE: design/primitive_field_serializer_top.sv
// Primitive field serializer: big-endian and varint encodings, one byte per cycle while out_ready holds.
// An accepted item is loaded into the shifter; each of its bytes then moves into the output register.
// Each item gives 1, 2, 4 or 8 bytes (fixed widths) or 1..5 / 1..10 bytes (varint32 / varint64),
// set by the byte-serial shift register; the next item is taken as the final byte is handed over.
// An undefined operation code is accepted and emits nothing.
// Reset (rst_n, synchronous, low): stream position to zero, pipeline emptied.
module primitive_field_serializer_top #(
  parameter int POSITION_WIDTH = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pfs_pkg::pfs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pfs_pkg::pfs_out_t out_data
);
  import pfs_pkg::*;

  pfs_digit_t              digit;
  logic                    advance;
  logic                    load;
  logic [OffsetWidth-1:0]  offset;
  logic                    out_valid_r;
  pfs_out_t                out_data_r;

  // Move the current byte into the output register when it is empty or being drained.
  assign advance = digit.busy && (!out_valid_r || out_ready);

  // A new item is taken when the shifter is idle or is handing over its final byte.
  assign in_ready = !digit.busy || (advance && digit.last);
  assign load     = in_valid && in_ready;

  pfs_shifter u_shifter (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (load),
    .item  (in_data),
    .step  (advance),
    .digit (digit)
  );

  pfs_position #(
    .PositionWidth (POSITION_WIDTH)
  ) u_position (
    .clk    (clk),
    .rst_n  (rst_n),
    .inc    (advance),
    .offset (offset)
  );

  // Output register: parts the shifter from the downstream stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (advance) begin
      out_data_r.out_byte    <= digit.data;
      out_data_r.byte_offset <= offset;
      out_data_r.last        <= digit.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: design/pfs_checker.sv
// Port-level checks for the serializer, bound to the top level.
module pfs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input pfs_pkg::pfs_out_t out_data,
  input logic              out_valid,
  input logic              out_ready
);
  import pfs_pkg::*;

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result visible after reset");

  // stalled mid-item byte: rest of the item still in the shifter, no new item taken
  a_no_take_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && !out_data.last |-> !(in_valid && in_ready))
    else $error("item taken while previous one unfinished");

  // consecutive bytes of one item carry consecutive offsets
  a_offset_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last ##1 out_valid
    |-> out_data.byte_offset == $past(out_data.byte_offset) + 48'd1
        || out_data.byte_offset == 48'd0)
    else $error("offset did not advance by one");

endmodule

bind primitive_field_serializer_top pfs_checker u_pfs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_ready (out_ready)
);

FILE: tb/sv/tb_primitive_field_serializer_top.sv
// Self-checking testbench for primitive_field_serializer_top: byte prediction and stream checks.

// Tracks the serialized byte stream: works out the bytes each accepted item should
// produce and compares them, in order, with those the block emits.
class field_byte_tracker;
  pfs_pkg::pfs_out_t stream_bytes[$];
  logic [pfs_pkg::OffsetWidth-1:0] next_offset;
  int mismatches;

  function new();
    next_offset = '0;
    mismatches = 0;
  endfunction

  function void push_byte(logic [7:0] b, logic is_last);
    pfs_pkg::pfs_out_t e;
    e.out_byte = b;
    e.byte_offset = next_offset;
    e.last = is_last;
    stream_bytes.push_back(e);
    next_offset = next_offset + 1'b1;  // wraps at 48 bits
  endfunction

  function void push_big_endian(logic [63:0] v, int nbytes);
    for (int k = nbytes - 1; k >= 0; k--) begin
      push_byte(v[8*k +: 8], k == 0);
    end
  endfunction

  function void push_varint(logic [63:0] v);
    while (v[63:7] != '0) begin
      push_byte({1'b1, v[6:0]}, 1'b0);
      v = v >> 7;
    end
    push_byte({1'b0, v[6:0]}, 1'b1);
  endfunction

  // Called once per accepted item.
  function void note_item(pfs_pkg::pfs_in_t it);
    case (it.operation)
      pfs_pkg::OP_BYTE:     push_big_endian(it.value, 1);
      pfs_pkg::OP_INT16:    push_big_endian(it.value, 2);
      pfs_pkg::OP_INT32:    push_big_endian(it.value, 4);
      pfs_pkg::OP_INT64:    push_big_endian(it.value, 8);
      pfs_pkg::OP_VARINT32: push_varint({32'h0, it.value[31:0]});
      pfs_pkg::OP_VARINT64: push_varint(it.value);
      default: ;  // undefined codes emit nothing
    endcase
  endfunction

  function void report(string what, pfs_pkg::pfs_out_t e, pfs_pkg::pfs_out_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s): expected byte %h offset %h last %b, got byte %h offset %h last %b",
               what, e.out_byte, e.byte_offset, e.last,
               got.out_byte, got.byte_offset, got.last);
    end
  endfunction

  // Called once per accepted output byte.
  function void check_byte(pfs_pkg::pfs_out_t got);
    pfs_pkg::pfs_out_t e;
    if (stream_bytes.size() == 0) begin
      e = '0;
      report("unexpected byte", e, got);
      return;
    end
    e = stream_bytes.pop_front();
    if (got.out_byte !== e.out_byte) report("out_byte", e, got);
    else if (got.byte_offset !== e.byte_offset) report("byte_offset", e, got);
    else if (got.last !== e.last) report("last", e, got);
  endfunction

  function int pending();
    return stream_bytes.size();
  endfunction
endclass

module tb_primitive_field_serializer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pfs_pkg::*;

  // Codes the block must drop without emitting anything
  localparam logic [2:0] OP_UNDEF_LO = 3'd6;
  localparam logic [2:0] OP_UNDEF_HI = 3'd7;

  localparam int RandomPerPhase = 48;
  localparam int CycleLimit = 400000;
  // A 64-bit varint gives at most ten bytes; allow a margin after the stream drains
  localparam int DrainCycles = 30;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  pfs_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  pfs_out_t out_data;

  // Percentages for the current idling phase
  int send_idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;

  field_byte_tracker tracker = new();

  primitive_field_serializer_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb_primitive_field_serializer_top failed");
      $finish;
    end
  end

  // Receiver side: check each accepted byte, then pick this cycle's ready.
  // Values read here are the ones the block saw at this edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tracker.check_byte(out_data);
    end
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Offer one item; optional idle cycles first. Valid stays high across
  // back-to-back items, so it only drops when an idle cycle is taken.
  task automatic send_item(input pfs_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_item(it);
  endtask

  task automatic send_op(input logic [2:0] op, input logic [63:0] v);
    pfs_in_t it;
    it.operation = op;
    it.value = v;
    send_item(it);
  endtask

  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    // Mostly shorten the value so that every varint length turns up
    if ($urandom_range(3) != 0) v = v >> $urandom_range(63);
    return v;
  endfunction

  // Random items until the requested number of defined operations is sent;
  // dropped codes are sprinkled in but not counted.
  task automatic send_random(input int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 6) begin
        send_op($urandom_range(1) ? OP_UNDEF_HI : OP_UNDEF_LO, {$urandom, $urandom});
      end else begin
        send_op(3'($urandom_range(OP_VARINT64, OP_BYTE)), rand_value());
        sent++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, every operation and the corner cases.
    send_op(OP_BYTE,     64'h0);
    send_op(OP_BYTE,     64'hFFFF_FFFF_FFFF_FFFF);
    send_op(OP_INT16,    64'h0);
    send_op(OP_INT16,    64'hA5A5_0000_5A5A_ABCD);
    send_op(OP_INT32,    64'hFFFF_FFFF_FFFF_FFFF);
    send_op(OP_INT32,    64'h0000_0000_1234_5678);
    send_op(OP_INT64,    64'h0);
    send_op(OP_INT64,    64'h0123_4567_89AB_CDEF);
    send_op(OP_INT64,    64'hFFFF_FFFF_FFFF_FFFF);
    send_op(OP_UNDEF_LO, 64'h1234);
    send_op(OP_VARINT32, 64'h0);                    // zero varint, single byte
    send_op(OP_VARINT32, 64'h7F);
    send_op(OP_VARINT32, 64'h80);
    send_op(OP_VARINT32, 64'hFFFF_FFFF);
    send_op(OP_VARINT32, 64'hDEAD_BEEF_0000_0000);  // upper half ignored -> zero
    send_op(OP_VARINT32, 64'hFFFF_FFFF_0000_3FFF);
    send_op(OP_UNDEF_HI, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(OP_VARINT64, 64'h0);
    send_op(OP_VARINT64, 64'h3FFF);
    send_op(OP_VARINT64, 64'h8000_0000_0000_0000);
    send_op(OP_VARINT64, 64'hFFFF_FFFF_FFFF_FFFF);  // ten bytes
    send_op(OP_VARINT64, 64'h0000_0001_0000_0000);

    // Random phases with different idling on each side.
    send_random(RandomPerPhase);
    send_idle_pct = 88;
    send_random(RandomPerPhase);
    send_idle_pct = 0;
    stall_pct = 88;
    send_random(RandomPerPhase);
    send_idle_pct = 35;
    stall_pct = 35;
    send_random(RandomPerPhase);
    in_valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("tb_primitive_field_serializer_top passed");
    end else begin
      $display("tb_primitive_field_serializer_top failed");
    end
    $finish;
  end

endmodule
